// ===== hw/rtl/bitmap_block_allocator_assert.svh =====
// Assertion macros shared by the bitmap block allocator RTL.
// No dependencies; included by modules that carry assertions.
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define BBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bba_pkg.sv =====
// Shared types, codes and helpers of the bitmap block allocator.
// No dependencies.
package bba_pkg;

    localparam logic [1:0] KIND_FIRST_FIT = 2'd0;
    localparam logic [1:0] KIND_BUDDY     = 2'd1;
    localparam logic [1:0] KIND_FREE      = 2'd2;
    localparam logic [1:0] KIND_BUDDY_FREE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [10:0] BEST_LIMIT    = 11'd2000;
    localparam logic [10:0] MAP_SIZE_RST  = 11'd1024;

    typedef struct packed {
        logic        wr;
        logic [10:0] map_size;
    } t_cfg;

    // round up to a power of two; zero stays zero
    function automatic logic [11:0] round_pow2(input logic [10:0] len);
        logic [11:0] v;
        begin
            v = {1'b0, len} - 12'd1;
            v = v | (v >> 1);
            v = v | (v >> 2);
            v = v | (v >> 4);
            v = v | (v >> 8);
            round_pow2 = (len == 11'd0) ? 12'd0 : v + 12'd1;
        end
    endfunction

endpackage

// ===== hw/rtl/bba_req_if.sv =====
// Request channel of the bitmap block allocator.
// No dependencies.
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  start_index;
    logic [10:0] block_length;

    modport source(output valid, kind, start_index, block_length, input ready);
    modport sink(input valid, kind, start_index, block_length, output ready);
endinterface

// ===== hw/rtl/bba_rsp_if.sv =====
// Response channel of the bitmap block allocator.
// No dependencies.
interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  result_index;
    logic [10:0] allocated_count;

    modport source(output valid, status, result_index, allocated_count, input ready);
    modport sink(input valid, status, result_index, allocated_count, output ready);
endinterface

// ===== hw/rtl/bba_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/bba_apb.sv =====
// APB register port of the bitmap block allocator (map_size).
// Depends on bba_pkg.
module bba_apb (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output bba_pkg::t_cfg    o_cfg
);
    logic [10:0] r_map_size;
    logic        wr_hit;

    assign wr_hit = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size <= bba_pkg::MAP_SIZE_RST;
        end else if (wr_hit) begin
            r_map_size <= pwdata[10:0];
        end
    end

    assign o_cfg.wr       = wr_hit;
    assign o_cfg.map_size = pwdata[10:0];
    assign prdata = paddr[2] ? 32'd0 : {21'd0, r_map_size};
    assign pready = 1'b1;
endmodule

// ===== hw/rtl/bba_engine.sv =====
// Request sequencer: scans, marks and clears the bitmap held in bba_ram.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ram and the assertion header.
`include "bitmap_block_allocator_assert.svh"
module bba_engine #(
    parameter int MAP_BITS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bba_pkg::t_cfg i_cfg,
    bba_req_if.sink       i_req,
    bba_rsp_if.source     o_rsp
);
    localparam int AW = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
    localparam int CW = ((AW > 11) ? AW : 11) + 2;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_MARK = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_kind, n_kind;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_run, n_run;
    logic [CW-1:0] r_need, n_need;
    logic [CW-1:0] r_best, n_best;
    logic [CW-1:0] r_pick, n_pick;
    logic [CW-1:0] r_end, n_end;
    logic [CW-1:0] r_lim, n_lim;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_hit, n_hit;
    logic [1:0]    r_status, n_status;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic          ram_rdata;

    logic [CW-1:0] len, pw, need, fend, run1, cfg_n;
    logic          is_alloc;

    bba_ram #(.WIDTH(1), .DEPTH(MAP_BITS)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign cfg_n = (CW'(i_cfg.map_size) > CW'(MAP_BITS)) ? CW'(MAP_BITS)
                                                         : CW'(i_cfg.map_size);

    always_comb begin
        n_state = r_state;  n_kind = r_kind;  n_i = r_i;  n_run = r_run;
        n_need = r_need;    n_best = r_best;  n_pick = r_pick;
        n_end = r_end;      n_lim = r_lim;    n_n = r_n;  n_cnt = r_cnt;
        n_hit = r_hit;      n_status = r_status;
        ram_we = 1'b0;  ram_waddr = r_i[AW-1:0];  ram_wdata = 1'b0;
        len  = CW'(i_req.block_length);
        pw   = CW'(bba_pkg::round_pow2(i_req.block_length));
        is_alloc = (i_req.kind == bba_pkg::KIND_FIRST_FIT) ||
                   (i_req.kind == bba_pkg::KIND_BUDDY);
        need = ((i_req.kind == bba_pkg::KIND_FIRST_FIT) ||
                (i_req.kind == bba_pkg::KIND_FREE)) ? len : pw;
        fend = CW'(i_req.start_index) + need;
        run1 = ram_rdata ? '0 : r_run + CW'(1);

        unique case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                n_cnt  = '0;
                if (r_i == CW'(MAP_BITS - 1)) begin
                    n_i = '0;
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind = i_req.kind;
                    n_need = need;
                    n_run  = '0;
                    n_best = CW'(bba_pkg::BEST_LIMIT);
                    n_hit  = 1'b0;
                    n_pick = '0;
                    if (is_alloc) begin
                        n_i   = '0;
                        n_lim = r_n;
                        if (need == '0 || need > r_n) begin
                            n_status = bba_pkg::ST_NOFIT;
                            n_state  = S_OUT;
                        end else begin
                            n_status = bba_pkg::ST_OK;
                            n_state  = S_RD;
                        end
                    end else begin
                        n_i      = CW'(i_req.start_index);
                        n_lim    = (fend > r_n) ? r_n : fend;
                        n_status = (fend > r_n) ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_i >= r_lim) begin
                    case (r_kind)
                        bba_pkg::KIND_FIRST_FIT: begin
                            n_status = bba_pkg::ST_NOFIT;
                            n_state  = S_OUT;
                        end
                        bba_pkg::KIND_BUDDY: begin
                            // a run reaching the map end is judged like any other
                            if (r_run >= r_need && r_run < r_best) begin
                                n_pick  = r_n - r_run;
                                n_i     = r_n - r_run;
                                n_end   = r_n - r_run + r_need;
                                n_state = S_MARK;
                            end else if (r_hit) begin
                                n_i     = r_pick;
                                n_end   = r_pick + r_need;
                                n_state = S_MARK;
                            end else begin
                                n_status = bba_pkg::ST_NOFIT;
                                n_state  = S_OUT;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end else begin
                    n_state = S_EV;
                end
            end
            S_EV: begin
                case (r_kind)
                    bba_pkg::KIND_FIRST_FIT: begin
                        n_run = run1;
                        if (run1 == r_need) begin
                            n_pick  = r_i + CW'(1) - r_need;
                            n_i     = r_i + CW'(1) - r_need;
                            n_end   = r_i + CW'(1);
                            n_state = S_MARK;
                        end else begin
                            n_i     = r_i + CW'(1);
                            n_state = S_RD;
                        end
                    end
                    bba_pkg::KIND_BUDDY: begin
                        if (ram_rdata) begin
                            if (r_run >= r_need && r_run < r_best) begin
                                n_best = r_run;
                                n_pick = r_i - r_run;
                                n_hit  = 1'b1;
                            end
                            n_i   = r_i - r_run + r_need;
                            n_run = '0;
                        end else begin
                            n_run = r_run + CW'(1);
                            n_i   = r_i + CW'(1);
                        end
                        n_state = S_RD;
                    end
                    default: begin
                        if (ram_rdata) begin
                            ram_we = 1'b1;
                            n_cnt  = r_cnt - CW'(1);
                        end
                        n_i     = r_i + CW'(1);
                        n_state = S_RD;
                    end
                endcase
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                if (r_i + CW'(1) == r_end) begin
                    n_cnt   = r_cnt + r_need;
                    n_state = S_OUT;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase

        if (i_cfg.wr) begin
            n_n     = cfg_n;
            n_i     = '0;
            n_state = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_i     <= '0;
            r_cnt   <= '0;
            r_n     <= (CW'(bba_pkg::MAP_SIZE_RST) > CW'(MAP_BITS)) ? CW'(MAP_BITS)
                                                                    : CW'(bba_pkg::MAP_SIZE_RST);
            r_kind  <= bba_pkg::KIND_FIRST_FIT;
            r_run   <= '0;
            r_need  <= '0;
            r_best  <= '0;
            r_pick  <= '0;
            r_end   <= '0;
            r_lim   <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_kind  <= n_kind;
            r_run   <= n_run;
            r_need  <= n_need;
            r_best  <= n_best;
            r_pick  <= n_pick;
            r_end   <= n_end;
            r_lim   <= n_lim;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = (r_state == S_OUT);
    assign o_rsp.status          = r_status;
    assign o_rsp.result_index    = r_pick[9:0];
    assign o_rsp.allocated_count = r_cnt[10:0];

    `BBA_ASSERT_NOW(a_no_rsp_when_idle, i_clk, i_rst_n, i_req.ready, !o_rsp.valid, "response valid while idle")
    `BBA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "accepted beat left block idle")
    `BBA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAP_BITS), "set bit count beyond map")
    `BBA_ASSERT_NOW(a_mark_in_map, i_clk, i_rst_n, r_state == S_MARK, r_i < r_end && r_end <= r_n, "mark outside map")
endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Channel   | dir | beat contents                                | handshake
// i_req     | in  | kind, start_index, block_length              | valid/ready
// o_rsp     | out | status, result_index, allocated_count        | valid/ready
// APB       | in  | map_size at bytes 0-3 (write clears the map) | psel/penable, pready=1
//
// One request at a time. Each bitmap bit is read and then evaluated on the single
// RAM read port. Buddy restarts the scan at start+p after each used bit, so a free
// run of length L ahead of a used bit is walked about L/p times. Reset and every
// map_size write run a clearing pass over all MAP_BITS bits with i_req.ready low.
// A stalled response holds the block until o_rsp.ready.
// Depends on bba_pkg, bba_req_if, bba_rsp_if, bba_apb, bba_engine.
module bitmap_block_allocator #(
    parameter int MAP_BITS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    bba_req_if.sink     i_req,
    bba_rsp_if.source   o_rsp
);
    bba_pkg::t_cfg cfg;

    // register port: map_size, to be written by the user only while idle; not enforced
    bba_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer and bitmap memory
    bba_engine #(.MAP_BITS(MAP_BITS)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );
endmodule
